### rtl/core/psw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psw_pkg
// Shared types and codes of the pausable stopwatch: modes, commands, result
// codes and the word types that pass between the top level and the core.
// ----------------------------------------------------------------------------
package psw_pkg;

	localparam int unsigned OP_W   = 3;
	localparam int unsigned USEC_W = 63;
	localparam int unsigned CODE_W = 3;
	localparam int unsigned MODE_W = 2;

	localparam logic [USEC_W-1:0] USEC_MAX = {USEC_W{1'b1}};

	typedef enum logic [MODE_W-1:0] {
		MODE_IDLE    = 2'd0,
		MODE_RUNNING = 2'd1,
		MODE_PAUSED  = 2'd2,
		MODE_STOPPED = 2'd3
	} mode_t;

	typedef enum logic [OP_W-1:0] {
		OP_START   = 3'd0,
		OP_STOP    = 3'd1,
		OP_PAUSE   = 3'd2,
		OP_RESTART = 3'd3,
		OP_READ    = 3'd4,
		OP_PEEK    = 3'd5
	} op_t;

	typedef enum logic [CODE_W-1:0] {
		RC_OK         = 3'd0,
		RC_RUNNING    = 3'd1,
		RC_IDLE       = 3'd2,
		RC_STOPPED    = 3'd3,
		RC_WRONG_MODE = 3'd4
	} rc_t;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [USEC_W-1:0] now_usec;
	} cmd_t;

	typedef struct packed {
		logic [CODE_W-1:0] result_code;
		logic [USEC_W-1:0] elapsed_usec;
		logic [MODE_W-1:0] mode_after;
	} rsp_t;

endpackage
`default_nettype wire

### rtl/core/psw_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psw_cmd_if / psw_rsp_if
// Valid/ready channels of the stopwatch: command words in, result words out.
// ----------------------------------------------------------------------------
interface psw_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [psw_pkg::OP_W-1:0]     operation;
	logic [psw_pkg::USEC_W-1:0]   now_usec;

	modport source (output valid, output operation, output now_usec, input ready);
	modport sink   (input valid, input operation, input now_usec, output ready);
	modport mon    (input valid, input operation, input now_usec, input ready);
endinterface

interface psw_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [psw_pkg::CODE_W-1:0]   result_code;
	logic [psw_pkg::USEC_W-1:0]   elapsed_usec;
	logic [psw_pkg::MODE_W-1:0]   mode_after;

	modport source (output valid, output result_code, output elapsed_usec,
		output mode_after, input ready);
	modport sink   (input valid, input result_code, input elapsed_usec,
		input mode_after, output ready);
	modport mon    (input valid, input result_code, input elapsed_usec,
		input mode_after, input ready);
endinterface
`default_nettype wire

### rtl/core/psw_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psw_core
// Stopwatch state (mode, segment start, accumulated time) and the per-command
// decision logic. The state advances on step; the result is combinational.
// ----------------------------------------------------------------------------
module psw_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire psw_pkg::cmd_t cmd,
	output psw_pkg::rsp_t      rsp
);

	psw_pkg::mode_t                mode_q, mode_d;
	logic [psw_pkg::USEC_W-1:0]    seg_start_q, seg_start_d;
	logic [psw_pkg::USEC_W-1:0]    acc_q, acc_d;

	psw_pkg::op_t                  op;
	logic                          seg_fwd;
	logic [psw_pkg::USEC_W-1:0]    seg_len;
	logic [psw_pkg::USEC_W+1:0]    sum_w;
	logic [psw_pkg::USEC_W-1:0]    acc_add;

	assign op      = psw_pkg::op_t'(cmd.operation);
	// time running backwards counts as an empty segment
	assign seg_fwd = cmd.now_usec >= seg_start_q;
	assign seg_len = seg_fwd ? (cmd.now_usec - seg_start_q) : '0;
	assign sum_w   = {2'b00, acc_q} + {2'b00, cmd.now_usec} - {2'b00, seg_start_q};

	always_comb begin
		if (!seg_fwd) begin
			acc_add = acc_q;
		end else if (|sum_w[psw_pkg::USEC_W+1:psw_pkg::USEC_W]) begin
			acc_add = psw_pkg::USEC_MAX;
		end else begin
			acc_add = sum_w[psw_pkg::USEC_W-1:0];
		end
	end

	// next state
	always_comb begin
		mode_d      = mode_q;
		seg_start_d = seg_start_q;
		acc_d       = acc_q;
		case (op)
			psw_pkg::OP_START: begin
				if (mode_q != psw_pkg::MODE_RUNNING) begin
					if (mode_q != psw_pkg::MODE_PAUSED) acc_d = '0;
					seg_start_d = cmd.now_usec;
					mode_d      = psw_pkg::MODE_RUNNING;
				end
			end
			psw_pkg::OP_STOP: begin
				if (mode_q == psw_pkg::MODE_RUNNING) acc_d = acc_add;
				if (mode_q != psw_pkg::MODE_IDLE) mode_d = psw_pkg::MODE_STOPPED;
			end
			psw_pkg::OP_PAUSE: begin
				if (mode_q == psw_pkg::MODE_RUNNING) begin
					acc_d  = acc_add;
					mode_d = psw_pkg::MODE_PAUSED;
				end
			end
			psw_pkg::OP_RESTART: begin
				acc_d       = '0;
				seg_start_d = cmd.now_usec;
				mode_d      = psw_pkg::MODE_RUNNING;
			end
			default: ;
		endcase
	end

	// result word
	always_comb begin
		rsp.result_code  = psw_pkg::RC_OK;
		rsp.elapsed_usec = '0;
		rsp.mode_after   = mode_d;
		case (op)
			psw_pkg::OP_START: begin
				if (mode_q == psw_pkg::MODE_RUNNING) rsp.result_code = psw_pkg::RC_RUNNING;
			end
			psw_pkg::OP_STOP: begin
				if (mode_q == psw_pkg::MODE_IDLE) rsp.result_code = psw_pkg::RC_IDLE;
			end
			psw_pkg::OP_PAUSE: begin
				if (mode_q == psw_pkg::MODE_IDLE) begin
					rsp.result_code = psw_pkg::RC_IDLE;
				end else if (mode_q == psw_pkg::MODE_STOPPED) begin
					rsp.result_code = psw_pkg::RC_STOPPED;
				end
			end
			psw_pkg::OP_READ: begin
				if (mode_q inside {psw_pkg::MODE_PAUSED, psw_pkg::MODE_STOPPED}) begin
					rsp.elapsed_usec = acc_q;
				end else begin
					rsp.result_code = psw_pkg::RC_WRONG_MODE;
				end
			end
			psw_pkg::OP_PEEK: begin
				if (mode_q == psw_pkg::MODE_RUNNING) begin
					rsp.elapsed_usec = seg_len;
				end else begin
					rsp.result_code = psw_pkg::RC_WRONG_MODE;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= psw_pkg::MODE_IDLE;
			seg_start_q <= '0;
			acc_q       <= '0;
		end else if (step) begin
			mode_q      <= mode_d;
			seg_start_q <= seg_start_d;
			acc_q       <= acc_d;
		end
	end

endmodule
`default_nettype wire

### rtl/core/pausable_stopwatch_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pausable_stopwatch_top
// Stopwatch with idle, running, paused and stopped modes, driven by
// timestamped commands.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one command word per handshake: operation and now_usec.
//   rsp returns exactly one result word per command, in order: result_code,
//   elapsed_usec and the mode after the command.
//   An accepted word is first held in the input register; the decision
//   and state update then write the result register, where rsp.valid
//   rises. Throughput is one word per cycle while the receiver does not
//   stall; the state update is a single pass of the mode logic and a
//   65-bit add and subtract, saturated to USEC_MAX.
//   The input register refills while the result register still holds an
//   unread word. When the receiver stalls, one word waits in each register
//   and cmd.ready drops; nothing is lost or repeated.
//   Reset puts the stopwatch in idle with zero segment start and zero
//   accumulated time, and empties both registers.
// ----------------------------------------------------------------------------
module pausable_stopwatch_top (
	input  wire logic clk,
	input  wire logic arst_n,
	psw_cmd_if.sink   cmd,
	psw_rsp_if.source rsp
);

	logic          valid_s1;
	psw_pkg::cmd_t cmd_s1;
	logic          rsp_valid_q;
	psw_pkg::rsp_t rsp_q;
	psw_pkg::rsp_t rsp_d;
	logic          step;

	// s1 word moves into the result register when that one is free or drains
	assign step      = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign cmd.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			cmd_s1.operation <= cmd.operation;
			cmd_s1.now_usec  <= cmd.now_usec;
		end
	end

	psw_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.cmd    (cmd_s1),
		.rsp    (rsp_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (step) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) rsp_q <= rsp_d;
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.result_code  = rsp_q.result_code;
	assign rsp.elapsed_usec = rsp_q.elapsed_usec;
	assign rsp.mode_after   = rsp_q.mode_after;

endmodule
`default_nettype wire

### rtl/core/psw_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psw_chk
// Port-level checks of the stopwatch, bound to the top level.
// ----------------------------------------------------------------------------
module psw_chk (
	input wire logic  clk,
	input wire logic  arst_n,
	psw_cmd_if.sink   cmd,
	psw_rsp_if.source rsp
);

	// a stalled result word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.result_code)
			&& $stable(rsp.elapsed_usec) && $stable(rsp.mode_after))
		else $error("psw: result word changed while stalled");

	// once an accepted command has passed the input register, rsp holds a word
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> ##1 rsp.valid)
		else $error("psw: no result word two cycles after acceptance");

	// errors never report time
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.result_code != psw_pkg::RC_OK |-> rsp.elapsed_usec == '0)
		else $error("psw: nonzero elapsed time on an error word");

	// already-running error leaves the stopwatch running
	a_running_err: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.result_code == psw_pkg::RC_RUNNING
			|-> rsp.mode_after == psw_pkg::MODE_RUNNING)
		else $error("psw: already-running error with mode other than running");

endmodule

bind pausable_stopwatch_top psw_chk u_psw_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.cmd    (cmd),
	.rsp    (rsp)
);
`default_nettype wire

### sim/pausable_stopwatch_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pausable_stopwatch_top_tb
// Self-checking bench for the pausable stopwatch. A directed pass covers
// every command, most in several modes, unused opcodes, time running
// backwards and accumulator saturation. Random command streams with
// mostly forward-moving timestamps follow. Both channels idle at random.
// A scoreboard class predicts each result word and compares it in order.
// ----------------------------------------------------------------------------
module pausable_stopwatch_top_tb;
	import psw_pkg::*;

	localparam int RANDOM_WORDS = 1400;
	localparam int DRAIN_EVERY  = 350;
	localparam int TAIL_CYCLES  = 10;
	localparam int FLUSH_LIMIT  = 2000;

	class stopwatch_scoreboard;
		mode_t             mode      = MODE_IDLE;
		logic [USEC_W-1:0] seg_start = '0;
		logic [USEC_W-1:0] accum     = '0;
		rsp_t              expected_words[$];
		int                errors    = 0;

		function void note_command(logic [OP_W-1:0] op, logic [USEC_W-1:0] now);
			rsp_t              r;
			logic [USEC_W-1:0] seg;
			logic [USEC_W:0]   sum;
			seg = (now >= seg_start) ? now - seg_start : '0;
			sum = {1'b0, accum} + {1'b0, seg};
			r.result_code  = RC_OK;
			r.elapsed_usec = '0;
			case (op)
				OP_START: begin
					if (mode == MODE_RUNNING) begin
						r.result_code = RC_RUNNING;
					end else begin
						if (mode != MODE_PAUSED)
							accum = '0;
						seg_start = now;
						mode = MODE_RUNNING;
					end
				end
				OP_STOP: begin
					if (mode == MODE_IDLE) begin
						r.result_code = RC_IDLE;
					end else begin
						if (mode == MODE_RUNNING)
							accum = sum[USEC_W] ? USEC_MAX : sum[USEC_W-1:0];
						mode = MODE_STOPPED;
					end
				end
				OP_PAUSE: begin
					if (mode == MODE_IDLE) begin
						r.result_code = RC_IDLE;
					end else if (mode == MODE_RUNNING) begin
						accum = sum[USEC_W] ? USEC_MAX : sum[USEC_W-1:0];
						mode = MODE_PAUSED;
					end else if (mode == MODE_STOPPED) begin
						r.result_code = RC_STOPPED;
					end
				end
				OP_RESTART: begin
					accum = '0;
					seg_start = now;
					mode = MODE_RUNNING;
				end
				OP_READ: begin
					if (mode == MODE_PAUSED || mode == MODE_STOPPED)
						r.elapsed_usec = accum;
					else
						r.result_code = RC_WRONG_MODE;
				end
				OP_PEEK: begin
					if (mode == MODE_RUNNING)
						r.elapsed_usec = seg;
					else
						r.result_code = RC_WRONG_MODE;
				end
				default: ;
			endcase
			r.mode_after = mode;
			expected_words.push_back(r);
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (expected_words.size() == 0) begin
				$display("%t: unexpected result word code=%0d elapsed=%0d mode=%0d",
					$realtime, got.result_code, got.elapsed_usec, got.mode_after);
				errors++;
				return;
			end
			want = expected_words.pop_front();
			if (got.result_code !== want.result_code) begin
				$display("%t: result_code mismatch: expected %0d, got %0d",
					$realtime, want.result_code, got.result_code);
				errors++;
			end
			if (got.elapsed_usec !== want.elapsed_usec) begin
				$display("%t: elapsed_usec mismatch: expected %0d, got %0d",
					$realtime, want.elapsed_usec, got.elapsed_usec);
				errors++;
			end
			if (got.mode_after !== want.mode_after) begin
				$display("%t: mode_after mismatch: expected %0d, got %0d",
					$realtime, want.mode_after, got.mode_after);
				errors++;
			end
		endfunction

		function int waiting();
			return expected_words.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	psw_cmd_if cmd_bus();
	psw_rsp_if rsp_bus();

	stopwatch_scoreboard sb = new;

	pausable_stopwatch_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.rsp    (rsp_bus)
	);

	always #1 clk = ~clk;

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	// Idle cycles before a word, with occasional quiet runs of back-to-back words.
	function automatic int draw_gap(ref int quiet_left);
		if (quiet_left > 0) begin
			quiet_left--;
			return 0;
		end
		if ($urandom_range(0, 9) == 0) begin
			quiet_left = int'($urandom_range(10, 40));
			return 0;
		end
		return int'($urandom_range(0, 16));
	endfunction

	int send_quiet = 0;

	// Called at a rising edge; returns at the edge where the word is taken.
	task automatic send_cmd(logic [OP_W-1:0] op, logic [USEC_W-1:0] now);
		int gap;
		gap = draw_gap(send_quiet);
		if (gap > 0) begin
			cmd_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_bus.valid     <= 1'b1;
		cmd_bus.operation <= op;
		cmd_bus.now_usec  <= now;
		@(negedge clk);
		while (!cmd_bus.ready) @(negedge clk);
		@(posedge clk);
		sb.note_command(op, now);
	endtask

	// Hold off until every predicted result word has come back.
	task automatic drain_results();
		cmd_bus.valid <= 1'b0;
		do @(posedge clk); while (sb.waiting() != 0);
	endtask

	initial begin : result_sink
		rsp_t got;
		int   stall;
		int   quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = draw_gap(quiet);
			if (stall > 0) begin
				rsp_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_bus.ready <= 1'b1;
			@(negedge clk);
			while (!rsp_bus.valid) @(negedge clk);
			got = {rsp_bus.result_code, rsp_bus.elapsed_usec, rsp_bus.mode_after};
			@(posedge clk);
			sb.check_result(got);
		end
	end

	initial begin : stimulus
		logic [USEC_W-1:0] clock_now;
		logic [OP_W-1:0]   op;
		logic [63:0]       wide;
		int                sent;
		int                next_drain;
		int                pick;
		int                flush;

		arst_n            <= 1'b0;
		cmd_bus.valid     <= 1'b0;
		cmd_bus.operation <= '0;
		cmd_bus.now_usec  <= '0;
		rsp_bus.ready     <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every command, most in several modes, backward time, saturation
		send_cmd(OP_READ, '0);
		send_cmd(OP_PEEK, '0);
		send_cmd(OP_STOP, 63'd5);
		send_cmd(OP_PAUSE, 63'd5);
		send_cmd(3'd6, USEC_MAX);
		send_cmd(3'd7, '0);
		send_cmd(OP_START, 63'd100);
		send_cmd(OP_START, 63'd150);
		send_cmd(OP_READ, 63'd200);
		send_cmd(OP_PEEK, 63'd250);
		send_cmd(OP_PEEK, 63'd50);
		send_cmd(OP_PAUSE, 63'd400);
		send_cmd(OP_PAUSE, 63'd401);
		send_cmd(OP_READ, 63'd402);
		send_cmd(OP_PEEK, 63'd403);
		send_cmd(OP_START, 63'd1000);
		send_cmd(OP_PAUSE, 63'd900);
		send_cmd(OP_STOP, 63'd950);
		send_cmd(OP_STOP, 63'd960);
		send_cmd(OP_PAUSE, 63'd970);
		send_cmd(OP_READ, 63'd980);
		send_cmd(OP_START, '0);
		send_cmd(OP_STOP, USEC_MAX);
		send_cmd(OP_RESTART, '0);
		send_cmd(OP_PAUSE, USEC_MAX);
		send_cmd(OP_START, '0);
		send_cmd(OP_PAUSE, 63'd1000);
		send_cmd(OP_READ, 63'd1001);
		drain_results();

		clock_now  = '0;
		sent       = 0;
		next_drain = DRAIN_EVERY;
		while (sent < RANDOM_WORDS) begin
			pick = int'($urandom_range(0, 99));
			if (pick < 70) begin
				clock_now = clock_now + USEC_W'($urandom_range(0, 1000));
			end else if (pick < 85) begin
				clock_now = clock_now + USEC_W'($urandom);
			end else if (pick < 92) begin
				wide = {$urandom, $urandom};
				clock_now = wide[USEC_W-1:0];
			end else if (pick < 97) begin
				// timestamp steps backwards
				wide = 64'($urandom_range(0, 500));
				clock_now = (clock_now > wide[USEC_W-1:0]) ? clock_now - wide[USEC_W-1:0] : '0;
			end else begin
				clock_now = USEC_MAX - USEC_W'($urandom_range(0, 1000));
			end

			pick = int'($urandom_range(0, 99));
			if (pick < 20)
				op = OP_START;
			else if (pick < 32)
				op = OP_STOP;
			else if (pick < 52)
				op = OP_PAUSE;
			else if (pick < 60)
				op = OP_RESTART;
			else if (pick < 78)
				op = OP_READ;
			else if (pick < 97)
				op = OP_PEEK;
			else
				op = OP_W'($urandom_range(6, 7));

			send_cmd(op, clock_now);
			if (op <= OP_PEEK)
				sent++;
			if (sent >= next_drain) begin
				next_drain += DRAIN_EVERY;
				drain_results();
			end
		end

		cmd_bus.valid <= 1'b0;
		flush = 0;
		while (sb.waiting() != 0 && flush < FLUSH_LIMIT) begin
			@(posedge clk);
			flush++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.waiting() != 0) begin
			$display("%t: %0d result words never arrived", $realtime, sb.waiting());
			sb.errors++;
		end

		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
